FILE: hdl/rpbp_pkg.sv
// Package for the raw pixel bit packer: mode codes, widths and the byte buffer type.
package rpbp_pkg;

	localparam logic MODE_RAW10 = 1'b0;
	localparam logic MODE_RAW12 = 1'b1;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned PIXEL_W   = 16;
	localparam int unsigned RAW10_W   = 10;
	localparam int unsigned RAW12_W   = 12;
	localparam int unsigned MAX_BYTES = 3;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef byte_t [MAX_BYTES-1:0] byte_buf_t;

endpackage

FILE: hdl/raw_pixel_bit_packer_unit.sv
// Raw pixel bit packer: packs 10-bit or 12-bit pixels from 16-bit words into a byte stream.
// A word's bytes are registered: the first appears on the master side in the cycle after
// the word is taken; in 12-bit mode the first pixel of a pair is held for the second.
// Throughput is set by the byte-wide output drain: the slave side holds while bytes remain
// in the buffer, and the next word is taken as the last byte leaves.
// Reset (arst_n low, asynchronous): mode 10-bit, reservoir, pair state and byte buffer empty.
module raw_pixel_bit_packer_unit
	import rpbp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration: pack_mode
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	// pixel words in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] pixel_word
	input  logic        s_tlast,   // frame_end
	// packed bytes out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] packed_byte
	output logic        m_tlast    // last_byte
);

	// Mode register and packing state
	logic        mode_q;
	logic [11:0] held_bits_q;     // leftover reservoir bits, or first pixel of a pair
	logic [2:0]  held_count_q;    // valid leftover bits in 10-bit mode
	logic        pair_pending_q;  // first pixel of a pair held in 12-bit mode

	// Result register: up to three bytes, head in entry 0
	byte_buf_t   obyte_q;
	logic [2:0]  olast_q;
	logic [1:0]  ocnt_q;

	logic s_acc, m_acc;

	// Next-state and result of the word on the slave side
	logic [15:0] acc10;
	logic [4:0]  total10;
	logic        two_full;
	logic [2:0]  rem10;
	byte_buf_t   nbyte;
	logic [2:0]  nlast;
	logic [1:0]  ncnt;
	logic [11:0] nheld_bits;
	logic [2:0]  nheld_count;
	logic        npair;
	logic [11:0] pix12;

	assign m_acc    = m_tvalid && m_tready;
	// Take a word when the buffer is empty or its last byte leaves in this cycle
	assign s_tready = (ocnt_q == 2'd0) || ((ocnt_q == 2'd1) && m_tready);
	assign s_acc    = s_tvalid && s_tready;

	assign m_tvalid = (ocnt_q != 2'd0);
	assign m_tdata  = obyte_q[0];
	assign m_tlast  = olast_q[0];

	assign pix12 = s_tdata[RAW12_W-1:0];

	always_comb begin
		// 10-bit reservoir: append the new bits above the leftovers
		acc10    = ({6'd0, s_tdata[RAW10_W-1:0]} << held_count_q) | {10'd0, held_bits_q[5:0]};
		total10  = {2'b00, held_count_q} + 5'd10;
		two_full = total10[4];
		rem10    = two_full ? 3'd0 : total10[2:0];

		nbyte       = '0;
		nlast       = '0;
		ncnt        = 2'd0;
		nheld_bits  = held_bits_q;
		nheld_count = held_count_q;
		npair       = pair_pending_q;

		if (mode_q == MODE_RAW10) begin
			nbyte[0] = acc10[7:0];
			nbyte[1] = acc10[15:8];
			ncnt     = two_full ? 2'd2 : 2'd1;
			if (s_tlast) begin
				// flush a partial byte, zero padded, and mark the final byte
				if (rem10 != 3'd0) begin
					ncnt = ncnt + 2'd1;
				end
				if (ncnt == 2'd2) begin
					nlast = 3'b010;
				end else begin
					nlast = 3'b001;
				end
				nheld_bits  = '0;
				nheld_count = 3'd0;
				npair       = 1'b0;
			end else begin
				nheld_bits  = two_full ? 12'd0 : {6'd0, acc10[13:8]};
				nheld_count = rem10;
			end
		end else begin
			if (pair_pending_q) begin
				nbyte[0]   = held_bits_q[11:4];
				nbyte[1]   = {held_bits_q[3:0], pix12[11:8]};
				nbyte[2]   = pix12[7:0];
				nlast      = {s_tlast, 2'b00};
				ncnt       = 2'd3;
				nheld_bits = '0;
				npair      = 1'b0;
			end else if (s_tlast) begin
				// odd final pixel: two bytes, low nibble in the upper half
				nbyte[0]   = pix12[11:4];
				nbyte[1]   = {pix12[3:0], 4'd0};
				nlast      = 3'b010;
				ncnt       = 2'd2;
				nheld_bits = '0;
				npair      = 1'b0;
			end else begin
				// hold the first pixel of the pair, no bytes yet
				nheld_bits = pix12;
				npair      = 1'b1;
			end
			nheld_count = 3'd0;
		end
	end

	// Mode and packing state; a mode write drops any partial frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= MODE_RAW10;
			held_bits_q    <= '0;
			held_count_q   <= '0;
			pair_pending_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q         <= cfg_wdata;
			held_bits_q    <= '0;
			held_count_q   <= '0;
			pair_pending_q <= 1'b0;
		end else if (s_acc) begin
			held_bits_q    <= nheld_bits;
			held_count_q   <= nheld_count;
			pair_pending_q <= npair;
		end
	end

	// Byte buffer count: load on a new word, otherwise advance on each byte taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ocnt_q <= 2'd0;
		end else if (s_acc) begin
			ocnt_q <= ncnt;
		end else if (m_acc) begin
			ocnt_q <= ocnt_q - 2'd1;
		end
	end

	// Byte buffer payload: load or shift towards the head
	always_ff @(posedge clk) begin
		if (s_acc) begin
			obyte_q <= nbyte;
			olast_q <= nlast;
		end else if (m_acc) begin
			obyte_q[0] <= obyte_q[1];
			obyte_q[1] <= obyte_q[2];
			olast_q    <= {1'b0, olast_q[2:1]};
		end
	end

`ifndef SYNTHESIS
	// A word is only taken into an empty or draining buffer
	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |-> (ocnt_q == 2'd0) || ((ocnt_q == 2'd1) && m_acc))
		else $error("word taken while bytes still pending");

	// The final byte of a frame is always the tail of the buffer
	a_last_is_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (ocnt_q == 2'd1))
		else $error("final byte not at buffer tail");

	// The reservoir never holds a whole byte
	a_held_count: assert property (@(posedge clk) disable iff (!arst_n)
		held_count_q <= 3'd6)
		else $error("reservoir count out of range");

	// A pending pair exists only in 12-bit mode, with an empty reservoir count
	a_pair_mode: assert property (@(posedge clk) disable iff (!arst_n)
		pair_pending_q |-> (mode_q == MODE_RAW12) && (held_count_q == 3'd0))
		else $error("pending pair outside 12-bit mode");
`endif

endmodule
